@@ design/rob_pkg.sv @@
// Shared types, widths and helpers of the ray versus oriented box hit core.
// Depends on nothing; every other design file uses it by scoped names.
package rob_pkg;

  // Base formats
  localparam int COORD_BITS     = 16;
  localparam int AXIS_FRAC_BITS = 14;
  localparam int AXIS_BITS      = AXIS_FRAC_BITS + 2;
  localparam int RAY_SHIFT      = AXIS_FRAC_BITS + 1;
  localparam int FACE_SHIFT     = 2 * AXIS_FRAC_BITS + 1;
  localparam int BOUND_SHIFT    = 2 * AXIS_FRAC_BITS;

  // Configuration port
  localparam int NUM_REGS  = 5;
  localparam int CFG_W     = 3 * COORD_BITS;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  // Derived arithmetic widths
  localparam int C_W    = COORD_BITS + 1;               // centre minus origin
  localparam int D_W    = 2 * AXIS_BITS + 2;            // direction dot axis
  localparam int CD_W   = C_W + AXIS_BITS + 2;          // offset dot axis
  localparam int A_W    = 2 * AXIS_BITS + 2;            // axis dot axis
  localparam int DA_W   = ((CD_W + 1 + RAY_SHIFT) > (A_W + C_W)) ?
                          (CD_W + 1 + RAY_SHIFT) : (A_W + C_W);
  localparam int DIST_W = DA_W + 1;                     // plane distance
  localparam int MAG_W  = DIST_W;                       // divider remainder
  localparam int Q_W    = COORD_BITS + AXIS_FRAC_BITS + 1; // quotient bits
  localparam int T_W    = Q_W + 1;                      // signed t
  localparam int T_LO_W = T_W / 2;
  localparam int T_HI_W = T_W - T_LO_W;
  localparam int P_W    = D_W + T_W;
  localparam int U_W    = P_W + 2;                      // face coordinate
  localparam int H_W    = ((COORD_BITS + RAY_SHIFT) > (AXIS_BITS + T_W) ?
                          (COORD_BITS + RAY_SHIFT) : (AXIS_BITS + T_W)) + 1;

  // Face axes per normal axis: X faces (z,y), Y faces (x,z), Z faces (x,y)
  localparam int U_AXIS [3] = '{2, 0, 0};
  localparam int V_AXIS [3] = '{1, 2, 1};
  // Slot of the off-diagonal axis product: 0 = x.y, 1 = x.z, 2 = y.z
  localparam int U_PAIR [3] = '{1, 0, 1};
  localparam int V_PAIR [3] = '{0, 2, 2};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CENTER = 3'd0,
    REG_AXIS_X = 3'd1,
    REG_AXIS_Y = 3'd2,
    REG_AXIS_Z = 3'd3,
    REG_EXTENT = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    SIDE_NONE  = 3'd0,
    SIDE_X_NEG = 3'd1,
    SIDE_X_POS = 3'd2,
    SIDE_Y_NEG = 3'd3,
    SIDE_Y_POS = 3'd4,
    SIDE_Z_NEG = 3'd5,
    SIDE_Z_POS = 3'd6
  } side_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic signed [AXIS_BITS-1:0]  direction_x;
    logic signed [AXIS_BITS-1:0]  direction_y;
    logic signed [AXIS_BITS-1:0]  direction_z;
  } in_t;

  typedef struct packed {
    logic [2:0]                   hit_side;
    logic signed [COORD_BITS-1:0] face_u;
    logic signed [COORD_BITS-1:0] face_v;
    logic signed [COORD_BITS-1:0] hit_x;
    logic signed [COORD_BITS-1:0] hit_y;
    logic signed [COORD_BITS-1:0] hit_z;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0]      center;
    logic [2:0][CFG_W-1:0] axis;
    logic [CFG_W-1:0]      extent;
  } cfg_t;

  typedef logic [2:0][COORD_BITS-1:0] cvec_t;
  typedef logic [2:0][AXIS_BITS-1:0]  avec_t;
  typedef logic [2:0][C_W-1:0]        dvec_t;

  // Ray data carried alongside the divider lanes
  typedef struct packed {
    cvec_t      org;
    avec_t      dir;
    logic [2:0] cand;   // direction not parallel to this axis
    logic [2:0] sneg;   // candidate face is the minus face
    logic [2:0] tneg;   // plane distance negative
  } side_t;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [D_W-1:0]   dm;
    logic [Q_W-1:0]   q;
  } lane_t;

  typedef struct packed {
    lane_t [2:0] lane;
    side_t       side;
  } div_t;

  function automatic avec_t cfg_axis(cfg_t c, logic [1:0] i);
    avec_t r;
    for (int k = 0; k < 3; k++) begin
      r[k] = c.axis[i][k*COORD_BITS +: AXIS_BITS];
    end
    return r;
  endfunction

  function automatic cvec_t cfg_center(cfg_t c);
    cvec_t r;
    for (int k = 0; k < 3; k++) begin
      r[k] = c.center[k*COORD_BITS +: COORD_BITS];
    end
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] cfg_extent(cfg_t c, logic [1:0] k);
    return c.extent[k*COORD_BITS +: COORD_BITS];
  endfunction

  function automatic dvec_t vec_diff(cvec_t a, cvec_t b);
    dvec_t r;
    for (int k = 0; k < 3; k++) begin
      r[k] = $signed(a[k]) - $signed(b[k]);
    end
    return r;
  endfunction

  function automatic logic signed [D_W-1:0] dot_dir(avec_t p, avec_t q);
    logic signed [D_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      acc = acc + $signed(p[k]) * $signed(q[k]);
    end
    return acc;
  endfunction

  function automatic logic signed [A_W-1:0] dot_ax(avec_t p, avec_t q);
    logic signed [A_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      acc = acc + $signed(p[k]) * $signed(q[k]);
    end
    return acc;
  endfunction

  function automatic logic signed [CD_W-1:0] dot_c(dvec_t p, avec_t q);
    logic signed [CD_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      acc = acc + $signed(p[k]) * $signed(q[k]);
    end
    return acc;
  endfunction

  // Clamp a wide signed value to the coordinate range
  function automatic logic [COORD_BITS-1:0] sat_coord(logic signed [U_W-1:0] v);
    logic signed [U_W-1:0] hi;
    logic signed [U_W-1:0] lo;
    logic [COORD_BITS-1:0] r;
    hi = $signed((U_W'(1) << (COORD_BITS - 1)) - U_W'(1));
    lo = ~hi;
    if (v > hi) begin
      r = hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      r = lo[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

@@ design/ray_oriented_box_hit_core.sv @@
// Top level of the ray versus oriented box hit core: configuration registers,
// global pipeline advance, and the front, divider and back pipeline sections.
// Depends on rob_pkg, rob_front, rob_div and rob_back.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------
//   in      | input     | in_valid_i / in_stall_o    | in_data_i  (rob_pkg::in_t)
//   out     | output    | out_valid_o / out_stall_i  | out_data_o (rob_pkg::out_t)
//   cfg     | input     | cfg_we_i, no back-pressure | cfg_idx_i, cfg_wdata_i
//
// One ray beat is taken per cycle while the output is not stalled. The pipeline
// has three front stages, one divider stage per quotient bit, and
// seven back stages ending in the output register.
// Reset clears the valid bits and the configuration registers (box all zero).
// A stalled output beat freezes every stage at once; no beat is dropped or
// duplicated, and the input stalls in the same cycle.
module ray_oriented_box_hit_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rob_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rob_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [rob_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rob_pkg::CFG_W-1:0]         cfg_wdata_i
);

  // Configuration registers; writes to unused indexes are dropped.
  rob_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (rob_pkg::reg_idx_e'(cfg_idx_i))
        rob_pkg::REG_CENTER: cfg_q.center  <= cfg_wdata_i;
        rob_pkg::REG_AXIS_X: cfg_q.axis[0] <= cfg_wdata_i;
        rob_pkg::REG_AXIS_Y: cfg_q.axis[1] <= cfg_wdata_i;
        rob_pkg::REG_AXIS_Z: cfg_q.axis[2] <= cfg_wdata_i;
        rob_pkg::REG_EXTENT: cfg_q.extent  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless a finished beat is held at the output.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic          front_valid;
  rob_pkg::div_t front_data;
  logic          div_valid;
  rob_pkg::div_t div_data;

  // Dot products and plane distance per box axis
  rob_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (front_valid),
    .data_o  (front_data)
  );

  // t = distance / (direction . normal), truncated and clamped, all three axes
  rob_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (front_valid),
    .data_i  (front_data),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  // Face coordinates, bound test, face select and hit point
  rob_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (div_valid),
    .data_i  (div_data),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

@@ design/rob_front.sv @@
// Front end: axis dot products, plane distance per axis, divider operands.
// Depends on rob_pkg.
module rob_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  rob_pkg::in_t   data_i,
  input  rob_pkg::cfg_t  cfg_i,
  output logic           valid_o,
  output rob_pkg::div_t  data_o
);

  rob_pkg::cvec_t org_in;
  rob_pkg::avec_t dir_in;

  assign org_in = {data_i.origin_z, data_i.origin_y, data_i.origin_x};
  assign dir_in = {data_i.direction_z, data_i.direction_y, data_i.direction_x};

  // Stage 1: dot products
  logic                             v1_q;
  rob_pkg::cvec_t                   org1_q;
  rob_pkg::avec_t                   dir1_q;
  logic signed [rob_pkg::D_W-1:0]  d1_d [3], d1_q [3];
  logic signed [rob_pkg::CD_W-1:0] c1_d [3], c1_q [3];
  logic signed [rob_pkg::A_W-1:0]  a1_d [3], a1_q [3];

  always_comb begin
    rob_pkg::dvec_t off;
    rob_pkg::avec_t ax;
    off = rob_pkg::vec_diff(rob_pkg::cfg_center(cfg_i), org_in);
    for (int n = 0; n < 3; n++) begin
      ax      = rob_pkg::cfg_axis(cfg_i, 2'(n));
      d1_d[n] = rob_pkg::dot_dir(dir_in, ax);
      c1_d[n] = rob_pkg::dot_c(off, ax);
      a1_d[n] = rob_pkg::dot_ax(ax, ax);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      org1_q <= org_in;
      dir1_q <= dir_in;
      d1_q   <= d1_d;
      c1_q   <= c1_d;
      a1_q   <= a1_d;
    end
  end

  // Stage 2: signed plane distance
  logic                              v2_q;
  rob_pkg::cvec_t                    org2_q;
  rob_pkg::avec_t                    dir2_q;
  logic signed [rob_pkg::D_W-1:0]    d2_q [3];
  logic signed [rob_pkg::DIST_W-1:0] dist2_d [3], dist2_q [3];

  always_comb begin
    logic signed [rob_pkg::DIST_W-1:0] cs;
    logic signed [rob_pkg::C_W-1:0]    sz;
    for (int n = 0; n < 3; n++) begin
      sz         = $signed({1'b0, rob_pkg::cfg_extent(cfg_i, 2'(n))});
      cs         = (d1_q[n] < 0) ? -c1_q[n] : c1_q[n];
      dist2_d[n] = (cs <<< rob_pkg::RAY_SHIFT) - a1_q[n] * sz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      org2_q  <= org1_q;
      dir2_q  <= dir1_q;
      d2_q    <= d1_q;
      dist2_q <= dist2_d;
    end
  end

  // Stage 3: magnitudes and signs for the divider
  logic          v3_q;
  rob_pkg::div_t data3_d, data3_q;

  always_comb begin
    data3_d          = '0;
    data3_d.side.org = org2_q;
    data3_d.side.dir = dir2_q;
    for (int n = 0; n < 3; n++) begin
      data3_d.lane[n].rem  = (dist2_q[n] < 0) ? -dist2_q[n] : dist2_q[n];
      data3_d.lane[n].dm   = (d2_q[n] < 0) ? -d2_q[n] : d2_q[n];
      data3_d.side.cand[n] = (d2_q[n] != 0);
      data3_d.side.sneg[n] = (d2_q[n] < 0);
      data3_d.side.tneg[n] = (dist2_q[n] < 0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data3_q <= data3_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = data3_q;

endmodule

@@ design/rob_div.sv @@
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Depends on rob_pkg; the ray sideband rides along unchanged.
module rob_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  rob_pkg::div_t  data_i,
  output logic           valid_o,
  output rob_pkg::div_t  data_o
);

  rob_pkg::div_t stg_q [rob_pkg::Q_W];
  logic          vld_q [rob_pkg::Q_W];

  for (genvar i = 0; i < rob_pkg::Q_W; i++) begin : g_stage
    rob_pkg::div_t cur;
    rob_pkg::div_t nxt;
    logic          cur_v;

    if (i == 0) begin : g_first
      assign cur   = data_i;
      assign cur_v = valid_i;
    end else begin : g_next
      assign cur   = stg_q[i-1];
      assign cur_v = vld_q[i-1];
    end

    // A quotient above the limit leaves every bit set, which is the clamp.
    always_comb begin
      nxt = cur;
      for (int n = 0; n < 3; n++) begin
        if ((cur.lane[n].rem >> (rob_pkg::Q_W - 1 - i)) >=
            rob_pkg::MAG_W'(cur.lane[n].dm)) begin
          nxt.lane[n].rem = cur.lane[n].rem -
            (rob_pkg::MAG_W'(cur.lane[n].dm) << (rob_pkg::Q_W - 1 - i));
          nxt.lane[n].q[rob_pkg::Q_W-1-i] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv_i) begin
        vld_q[i] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        stg_q[i] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[rob_pkg::Q_W-1];
  assign data_o  = stg_q[rob_pkg::Q_W-1];

endmodule

@@ design/rob_back.sv @@
// Back end: face coordinates, bound test, first-face select, hit point.
// Depends on rob_pkg; ends in the output register of the core.
module rob_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  rob_pkg::div_t  data_i,
  input  rob_pkg::cfg_t  cfg_i,
  output logic           valid_o,
  output rob_pkg::out_t  data_o
);

  function automatic rob_pkg::side_e side_code(logic [1:0] n, logic neg);
    rob_pkg::side_e r;
    case (n)
      2'd0:    r = neg ? rob_pkg::SIDE_X_NEG : rob_pkg::SIDE_X_POS;
      2'd1:    r = neg ? rob_pkg::SIDE_Y_NEG : rob_pkg::SIDE_Y_POS;
      2'd2:    r = neg ? rob_pkg::SIDE_Z_NEG : rob_pkg::SIDE_Z_POS;
      default: r = rob_pkg::SIDE_NONE;
    endcase
    return r;
  endfunction

  // Stage 1: signed t, dot products recomputed from the carried ray
  logic                             v1_q;
  rob_pkg::side_t                   s1_q;
  logic signed [rob_pkg::T_W-1:0]  t1_d [3], t1_q [3];
  logic signed [rob_pkg::D_W-1:0]  d1_d [3], d1_q [3];
  logic signed [rob_pkg::CD_W-1:0] c1_d [3], c1_q [3];
  logic signed [rob_pkg::A_W-1:0]  a1_d [3], a1_q [3];

  always_comb begin
    rob_pkg::dvec_t                 off;
    logic signed [rob_pkg::T_W-1:0] tq;
    off = rob_pkg::vec_diff(rob_pkg::cfg_center(cfg_i), data_i.side.org);
    for (int n = 0; n < 3; n++) begin
      tq      = $signed({1'b0, data_i.lane[n].q});
      t1_d[n] = data_i.side.tneg[n] ? -tq : tq;
      d1_d[n] = rob_pkg::dot_dir(data_i.side.dir, rob_pkg::cfg_axis(cfg_i, 2'(n)));
      c1_d[n] = rob_pkg::dot_c(off, rob_pkg::cfg_axis(cfg_i, 2'(n)));
    end
    a1_d[0] = rob_pkg::dot_ax(rob_pkg::cfg_axis(cfg_i, 2'd0), rob_pkg::cfg_axis(cfg_i, 2'd1));
    a1_d[1] = rob_pkg::dot_ax(rob_pkg::cfg_axis(cfg_i, 2'd0), rob_pkg::cfg_axis(cfg_i, 2'd2));
    a1_d[2] = rob_pkg::dot_ax(rob_pkg::cfg_axis(cfg_i, 2'd1), rob_pkg::cfg_axis(cfg_i, 2'd2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q <= data_i.side;
      t1_q <= t1_d;
      d1_q <= d1_d;
      c1_q <= c1_d;
      a1_q <= a1_d;
    end
  end

  // Stage 2: partial products of (dir . axis) * t, split across t halves
  localparam int PH_W = rob_pkg::D_W + rob_pkg::T_HI_W;
  localparam int PL_W = rob_pkg::D_W + rob_pkg::T_LO_W + 1;
  localparam int AS_W = rob_pkg::A_W + rob_pkg::C_W;

  logic                             v2_q;
  rob_pkg::side_t                   s2_q;
  logic signed [rob_pkg::T_W-1:0]  t2_q [3];
  logic signed [PH_W-1:0]          ph2_d [3][2], ph2_q [3][2];
  logic signed [PL_W-1:0]          pl2_d [3][2], pl2_q [3][2];
  logic signed [rob_pkg::CD_W-1:0] c2_d [3][2], c2_q [3][2];
  logic signed [AS_W-1:0]          as2_d [3][2], as2_q [3][2];

  always_comb begin
    logic signed [rob_pkg::T_HI_W-1:0] thi;
    logic signed [rob_pkg::T_LO_W:0]   tlo;
    logic signed [rob_pkg::C_W-1:0]    sz;
    for (int n = 0; n < 3; n++) begin
      thi = t1_q[n][rob_pkg::T_W-1:rob_pkg::T_LO_W];
      tlo = $signed({1'b0, t1_q[n][rob_pkg::T_LO_W-1:0]});
      sz  = $signed({1'b0, rob_pkg::cfg_extent(cfg_i, 2'(n))});
      ph2_d[n][0] = d1_q[rob_pkg::U_AXIS[n]] * thi;
      pl2_d[n][0] = d1_q[rob_pkg::U_AXIS[n]] * tlo;
      c2_d[n][0]  = c1_q[rob_pkg::U_AXIS[n]];
      as2_d[n][0] = a1_q[rob_pkg::U_PAIR[n]] * sz;
      ph2_d[n][1] = d1_q[rob_pkg::V_AXIS[n]] * thi;
      pl2_d[n][1] = d1_q[rob_pkg::V_AXIS[n]] * tlo;
      c2_d[n][1]  = c1_q[rob_pkg::V_AXIS[n]];
      as2_d[n][1] = a1_q[rob_pkg::V_PAIR[n]] * sz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_q  <= s1_q;
      t2_q  <= t1_q;
      ph2_q <= ph2_d;
      pl2_q <= pl2_d;
      c2_q  <= c2_d;
      as2_q <= as2_d;
    end
  end

  // Stage 3: w = (dir . axis) * t - (offset . axis) << shift
  logic                             v3_q;
  rob_pkg::side_t                   s3_q;
  logic signed [rob_pkg::T_W-1:0]  t3_q [3];
  logic signed [rob_pkg::U_W-1:0]  w3_d [3][2], w3_q [3][2];
  logic signed [AS_W-1:0]          as3_q [3][2];

  always_comb begin
    logic signed [rob_pkg::U_W-1:0] hp;
    logic signed [rob_pkg::U_W-1:0] cp;
    for (int n = 0; n < 3; n++) begin
      for (int j = 0; j < 2; j++) begin
        hp         = ph2_q[n][j];
        cp         = c2_q[n][j];
        w3_d[n][j] = (hp <<< rob_pkg::T_LO_W) + pl2_q[n][j] - (cp <<< rob_pkg::RAY_SHIFT);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_q  <= s2_q;
      t3_q  <= t2_q;
      w3_q  <= w3_d;
      as3_q <= as2_q;
    end
  end

  // Stage 4: apply face sign, add the plane offset term
  logic                            v4_q;
  rob_pkg::side_t                  s4_q;
  logic signed [rob_pkg::T_W-1:0] t4_q [3];
  logic signed [rob_pkg::U_W-1:0] u4_d [3][2], u4_q [3][2];

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      for (int j = 0; j < 2; j++) begin
        u4_d[n][j] = s3_q.sneg[n] ? (as3_q[n][j] - w3_q[n][j]) : (as3_q[n][j] + w3_q[n][j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s4_q <= s3_q;
      t4_q <= t3_q;
      u4_q <= u4_d;
    end
  end

  // Stage 5: bound test, first passing face wins (X before Y before Z)
  logic                                   v5_q;
  rob_pkg::side_e                         code5_d, code5_q;
  logic [rob_pkg::COORD_BITS-1:0]         fu5_d, fu5_q, fv5_d, fv5_q;
  logic signed [rob_pkg::T_W-1:0]         t5_d, t5_q;
  logic                                   hit5_d, hit5_q;
  rob_pkg::cvec_t                         org5_q;
  rob_pkg::avec_t                         dir5_q;

  always_comb begin
    logic signed [rob_pkg::U_W-1:0] lu;
    logic signed [rob_pkg::U_W-1:0] lv;
    logic                           pass;
    code5_d = rob_pkg::SIDE_NONE;
    fu5_d   = '0;
    fv5_d   = '0;
    t5_d    = '0;
    hit5_d  = 1'b0;
    for (int n = 2; n >= 0; n--) begin
      lu   = rob_pkg::U_W'(rob_pkg::cfg_extent(cfg_i, 2'(rob_pkg::U_AXIS[n])));
      lv   = rob_pkg::U_W'(rob_pkg::cfg_extent(cfg_i, 2'(rob_pkg::V_AXIS[n])));
      lu   = lu <<< rob_pkg::BOUND_SHIFT;
      lv   = lv <<< rob_pkg::BOUND_SHIFT;
      pass = s4_q.cand[n] &&
             (u4_q[n][0] <= lu) && (u4_q[n][0] >= -lu) &&
             (u4_q[n][1] <= lv) && (u4_q[n][1] >= -lv);
      if (pass) begin
        code5_d = side_code(2'(n), s4_q.sneg[n]);
        fu5_d   = rob_pkg::sat_coord(u4_q[n][0] >>> rob_pkg::FACE_SHIFT);
        fv5_d   = rob_pkg::sat_coord(u4_q[n][1] >>> rob_pkg::FACE_SHIFT);
        t5_d    = t4_q[n];
        hit5_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      code5_q <= code5_d;
      fu5_q   <= fu5_d;
      fv5_q   <= fv5_d;
      t5_q    <= t5_d;
      hit5_q  <= hit5_d;
      org5_q  <= s4_q.org;
      dir5_q  <= s4_q.dir;
    end
  end

  // Stage 6: direction times t
  logic                            v6_q;
  rob_pkg::side_e                  code6_q;
  logic [rob_pkg::COORD_BITS-1:0]  fu6_q, fv6_q;
  logic                            hit6_q;
  rob_pkg::cvec_t                  org6_q;
  logic signed [rob_pkg::H_W-1:0]  p6_d [3], p6_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p6_d[k] = $signed(dir5_q[k]) * t5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (adv_i) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      code6_q <= code5_q;
      fu6_q   <= fu5_q;
      fv6_q   <= fv5_q;
      hit6_q  <= hit5_q;
      org6_q  <= org5_q;
      p6_q    <= p6_d;
    end
  end

  // Stage 7: hit point, floor and clamp, output register
  logic          v7_q;
  rob_pkg::out_t out7_d, out7_q;

  always_comb begin
    logic signed [rob_pkg::H_W-1:0] oe;
    logic signed [rob_pkg::U_W-1:0] hw;
    logic [rob_pkg::COORD_BITS-1:0] hp [3];
    for (int k = 0; k < 3; k++) begin
      oe    = $signed(org6_q[k]);
      hw    = (oe <<< rob_pkg::RAY_SHIFT) + p6_q[k];
      hp[k] = rob_pkg::sat_coord(hw >>> rob_pkg::RAY_SHIFT);
    end
    out7_d = '0;
    if (hit6_q) begin
      out7_d.hit_side = code6_q;
      out7_d.face_u   = fu6_q;
      out7_d.face_v   = fv6_q;
      out7_d.hit_x    = hp[0];
      out7_d.hit_y    = hp[1];
      out7_d.hit_z    = hp[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (adv_i) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out7_q <= out7_d;
    end
  end

  assign valid_o = v7_q;
  assign data_o  = out7_q;

endmodule

@@ sim/rob_checker.sv @@
// Scoreboard for the ray versus oriented box hit core: tracks register writes,
// predicts one hit record per accepted ray and compares it with the output beat.
// Depends on rob_pkg for the payload types and widths.
module rob_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  rob_pkg::in_t                  in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  rob_pkg::out_t                 out_data_i,
  input  logic                          cfg_we_i,
  input  logic [rob_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [rob_pkg::CFG_W-1:0]     cfg_wdata_i,
  output int                            errors_o,
  output int                            pending_o
);
  import rob_pkg::*;

  // Face order X+, X-, Y+, Y-, Z+, Z-: normal axis, face u/v axes, sign
  localparam side_e FACE_SIDE [6] = '{SIDE_X_POS, SIDE_X_NEG, SIDE_Y_POS,
                                      SIDE_Y_NEG, SIDE_Z_POS, SIDE_Z_NEG};
  localparam int FACE_N [6] = '{0, 0, 1, 1, 2, 2};
  localparam int FACE_A [6] = '{2, 2, 0, 0, 0, 0};
  localparam int FACE_B [6] = '{1, 1, 2, 2, 1, 1};
  localparam int FACE_S [6] = '{1, -1, 1, -1, 1, -1};
  localparam longint T_MAX = (64'sd1 <<< (COORD_BITS + AXIS_FRAC_BITS + 1)) - 1;

  logic [CFG_W-1:0] box_reg [NUM_REGS];
  out_t             hit_queue [$];

  function automatic logic [COORD_BITS-1:0] clamp_coord(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic longint field(logic [CFG_W-1:0] w, int k);
    logic [15:0] s;
    s = w[k*16 +: 16];
    return longint'($signed(s));
  endfunction

  function automatic out_t predict_hit(in_t ray);
    longint org [3], dir [3], cen [3], siz [3], ax [3][3];
    longint nrm [3], ua [3], va [3], r [3];
    longint d, pdist, t, u, v, lu, lv, dua, dva, rua, rva;
    longint scale;
    out_t   res;
    bit     found;
    scale = 64'sd1 <<< RAY_SHIFT;
    org[0] = ray.origin_x;    org[1] = ray.origin_y;    org[2] = ray.origin_z;
    dir[0] = ray.direction_x; dir[1] = ray.direction_y; dir[2] = ray.direction_z;
    for (int k = 0; k < 3; k++) begin
      cen[k] = field(box_reg[REG_CENTER], k);
      siz[k] = longint'(box_reg[REG_EXTENT][k*16 +: 16]);
      for (int i = 0; i < 3; i++) ax[i][k] = field(box_reg[REG_AXIS_X + i], k);
    end
    res = '0;
    found = 0;
    for (int f = 0; f < 6; f++) begin
      if (!found) begin
        for (int k = 0; k < 3; k++) begin
          nrm[k] = FACE_S[f] * ax[FACE_N[f]][k];
          ua[k]  = FACE_S[f] * ax[FACE_A[f]][k];
          va[k]  = FACE_S[f] * ax[FACE_B[f]][k];
        end
        d = dir[0]*nrm[0] + dir[1]*nrm[1] + dir[2]*nrm[2];
        if (d > 0) begin
          for (int k = 0; k < 3; k++)
            r[k] = cen[k]*scale - nrm[k]*siz[FACE_N[f]] - org[k]*scale;
          pdist = r[0]*nrm[0] + r[1]*nrm[1] + r[2]*nrm[2];
          t = pdist / d;
          if (t > T_MAX) t = T_MAX;
          if (t < -T_MAX) t = -T_MAX;
          dua = dir[0]*ua[0] + dir[1]*ua[1] + dir[2]*ua[2];
          dva = dir[0]*va[0] + dir[1]*va[1] + dir[2]*va[2];
          rua = r[0]*ua[0] + r[1]*ua[1] + r[2]*ua[2];
          rva = r[0]*va[0] + r[1]*va[1] + r[2]*va[2];
          u = dua*t - rua;
          v = dva*t - rva;
          lu = siz[FACE_A[f]] <<< BOUND_SHIFT;
          lv = siz[FACE_B[f]] <<< BOUND_SHIFT;
          if (!(u > lu || -u > lu || v > lv || -v > lv)) begin
            found = 1;
            res.hit_side = FACE_SIDE[f];
            res.face_u = clamp_coord(u >>> FACE_SHIFT);
            res.face_v = clamp_coord(v >>> FACE_SHIFT);
            res.hit_x  = clamp_coord((org[0]*scale + dir[0]*t) >>> RAY_SHIFT);
            res.hit_y  = clamp_coord((org[1]*scale + dir[1]*t) >>> RAY_SHIFT);
            res.hit_z  = clamp_coord((org[2]*scale + dir[2]*t) >>> RAY_SHIFT);
          end
        end
      end
    end
    return res;
  endfunction

  initial begin
    errors_o = 0;
    for (int i = 0; i < NUM_REGS; i++) box_reg[i] = '0;
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (cfg_we_i && cfg_idx_i < NUM_REGS) box_reg[cfg_idx_i] = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) hit_queue.push_back(predict_hit(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (hit_queue.size() == 0) begin
          $error("output beat with no ray pending");
          errors_o++;
        end else begin
          want = hit_queue.pop_front();
          if (out_data_i.hit_side !== want.hit_side) begin
            $error("hit_side: expected %0d, got %0d", want.hit_side, out_data_i.hit_side);
            errors_o++;
          end
          if (out_data_i.face_u !== want.face_u) begin
            $error("face_u: expected %0d, got %0d", want.face_u, out_data_i.face_u);
            errors_o++;
          end
          if (out_data_i.face_v !== want.face_v) begin
            $error("face_v: expected %0d, got %0d", want.face_v, out_data_i.face_v);
            errors_o++;
          end
          if (out_data_i.hit_x !== want.hit_x) begin
            $error("hit_x: expected %0d, got %0d", want.hit_x, out_data_i.hit_x);
            errors_o++;
          end
          if (out_data_i.hit_y !== want.hit_y) begin
            $error("hit_y: expected %0d, got %0d", want.hit_y, out_data_i.hit_y);
            errors_o++;
          end
          if (out_data_i.hit_z !== want.hit_z) begin
            $error("hit_z: expected %0d, got %0d", want.hit_z, out_data_i.hit_z);
            errors_o++;
          end
        end
      end
    end
    pending_o = hit_queue.size();
  end

endmodule

@@ sim/tb.sv @@
// Stimulus top for the ray versus oriented box hit core: clock, reset, box
// settings, ray beats and output stalls; the verdict comes from rob_checker.
// Depends on rob_pkg, ray_oriented_box_hit_core and rob_checker.
module tb;
  import rob_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int DRAIN = 50;       // idle margin after the last hit record, longer than the pipeline latency

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 in_valid = 0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 0;
  out_t                 out_data;
  logic                 cfg_we = 0;
  logic [REG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int                   errors;
  int                   pending;
  int                   cycles = 0;
  bit                   quiet = 0;     // no idling on either side
  bit                   hold_req = 0;  // ask the receiver for a long hold-off

  always #6 clk_i = ~clk_i;

  ray_oriented_box_hit_core u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  rob_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .errors_o(errors), .pending_o(pending)
  );

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off that lets
  // the pipeline fill up and push back on the input
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk_i);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 33);
      end
    end
  end

  function automatic logic [CFG_W-1:0] pack3(logic [15:0] x, logic [15:0] y,
                                             logic [15:0] z);
    return {z, y, x};
  endfunction

  // Signed value in -m..m
  function automatic logic [15:0] near(int m);
    return 16'($signed($urandom_range(0, 2*m)) - m);
  endfunction

  // Mostly rays from near the box with moderate direction, some full noise
  function automatic in_t make_ray();
    in_t r;
    if ($urandom_range(0, 3) == 0) begin
      r = {$urandom, $urandom, $urandom};
    end else begin
      r.origin_x = near(2560);  r.origin_y = near(2560);  r.origin_z = near(2560);
      r.direction_x = near(16384);
      r.direction_y = near(16384);
      r.direction_z = near(16384);
    end
    return r;
  endfunction

  // Wait for every hit record, then let the pipe run dry before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_box(logic [CFG_W-1:0] center, logic [CFG_W-1:0] ax,
                           logic [CFG_W-1:0] ay, logic [CFG_W-1:0] az,
                           logic [CFG_W-1:0] ext);
    logic [CFG_W-1:0] vals [NUM_REGS];
    vals = '{center, ax, ay, az, ext};
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= reg_idx_e'(i);
      cfg_wdata <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // Offer one beat, idling first at random, and hold it until taken
  task automatic send_ray(in_t r);
    if (!quiet && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic random_rays(int n);
    for (int i = 0; i < n; i++) send_ray(make_ray());
  endtask

  initial begin
    in_t r;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Box all zero out of reset: every face has d = 0, so no hit
    send_ray({16'h0100, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000});
    random_rays(40);
    drain();

    // Axis-aligned 4x4x4 box at the origin: directed rays
    write_box('0, pack3(16'h4000, 16'h0000, 16'h0000),
              pack3(16'h0000, 16'h4000, 16'h0000),
              pack3(16'h0000, 16'h0000, 16'h4000),
              pack3(16'h0400, 16'h0400, 16'h0400));
    send_ray({16'hf800, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000});
    send_ray({16'h0800, 16'h0000, 16'h0000, 16'hc000, 16'h0000, 16'h0000});
    send_ray({16'h0000, 16'hf800, 16'h0000, 16'h0000, 16'h4000, 16'h0000});
    send_ray({16'h0000, 16'h0800, 16'h0000, 16'h0000, 16'hc000, 16'h0000});
    send_ray({16'h0000, 16'h0000, 16'hf800, 16'h0000, 16'h0000, 16'h4000});
    send_ray({16'h0000, 16'h0000, 16'h0800, 16'h0000, 16'h0000, 16'hc000});
    send_ray({16'h0100, 16'h0200, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    // Grazing the face edge: hit lands exactly on the half extent
    send_ray({16'hf800, 16'h0200, 16'h0200, 16'h4000, 16'h0000, 16'h0000});
    send_ray({16'hf800, 16'h0201, 16'h0000, 16'h4000, 16'h0000, 16'h0000});
    // Field extremes, including a ray with a tiny direction and huge t
    send_ray({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    send_ray({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    send_ray({16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000});
    send_ray({16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
    send_ray({16'h7fff, 16'h7fff, 16'h7fff, 16'h0001, 16'h0001, 16'h0001});
    // Run this phase without idling on either side
    quiet = 1;
    random_rays(300);
    quiet = 0;
    drain();

    // A rotated, shifted box; a receiver hold-off in the middle
    write_box(pack3(near(768), near(768), near(768)),
              pack3(near(16384), near(16384), near(16384)),
              pack3(near(16384), near(16384), near(16384)),
              pack3(near(16384), near(16384), near(16384)),
              pack3(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048)),
                    16'($urandom_range(0, 2048))));
    random_rays(150);
    hold_req = 1;
    random_rays(150);
    // Sender pauses until every hit record is back, then resumes
    drain();
    random_rays(100);
    drain();

    // Register extremes
    write_box('1, '1, '1, '1, '1);
    random_rays(200);
    drain();
    write_box(pack3(16'h7fff, 16'h8000, 16'h7fff), pack3(16'h7fff, 16'h8000, 16'h7fff),
              pack3(16'h8000, 16'h7fff, 16'h8000), pack3(16'h7fff, 16'h7fff, 16'h8000),
              pack3(16'hffff, 16'h0000, 16'h8000));
    random_rays(200);
    drain();

    // Further random settings
    for (int p = 0; p < 4; p++) begin
      if (p == 0) begin
        write_box(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
                  CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
                  CFG_W'({$urandom, $urandom}));
      end else begin
        write_box(pack3(near(1024), near(1024), near(1024)),
                  pack3(near(16384), near(16384), near(16384)),
                  pack3(near(16384), near(16384), near(16384)),
                  pack3(near(16384), near(16384), near(16384)),
                  pack3(16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
                        16'($urandom_range(0, 4096))));
      end
      random_rays(220);
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
